@@ rtl/core/generational_handle_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// check on clk_i, idle while rst_ni is low
`define GHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on an explicit clock and active-low reset
`define GHA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define GHA_ASSERT(lbl, prop, msg)
`define GHA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`endif

`endif

@@ rtl/core/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, request and status codes, slot entry type and control states.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned GEN_W    = 16;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // one generation table entry: in-use flag above the generation count
  typedef struct packed {
    logic             in_use;
    logic [GEN_W-1:0] gen;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_e;

endpackage

@@ rtl/core/gha_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read until the next read enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/generational_handle_allocator_unit.sv @@
// Flow: a request is accepted in idle; the execute state registers its result, or the pop
// state for an allocate that pops a recycled index (stack read, then table read).
// Occupancy: one request in flight; the next is accepted only once back in idle.
// A waiting result does not stop the next transfer in; it only holds completion.
// Reset: asynchronous, active low; clears counters, control and output valid. The RAMs
// need no clearing pass: entries are only used after they have been written.
// ----------------------------------------------------------------------------
// Generational handle allocator
// Allocate, free and check handles of slot index plus generation, with the
// generation table and the LIFO free stack held in synchronous RAMs.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_unit_assert.svh"

module generational_handle_allocator_unit import gha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [9:0] handle_index, [25:10] handle_generation
  input  logic [7:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [9:0] out_index, [25:10] out_generation
  output logic [7:0]  m_axis_tuser   // [0] is_live, [2:1] status
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fsc_q, fsc_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [1:0]       req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [IDX_W-1:0] slot_q, slot_d;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [GEN_W-1:0] out_gen_q, out_gen_d;
  logic             out_live_q, out_live_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             res_load;

  logic             accept;
  logic             out_free;
  logic             hit;

  logic             gen_re, gen_we;
  logic [IDX_W-1:0] gen_raddr, gen_waddr;
  slot_t            gen_wdata, gen_rdata;
  logic [SLOT_W-1:0] gen_rdata_raw;

  logic             stk_re, stk_we;
  logic [IDX_W-1:0] stk_raddr, stk_waddr, stk_wdata, stk_rdata;

  gha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata_raw)
  );

  assign gen_rdata = gen_rdata_raw;

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign hit = ({1'b0, idx_q} < used_q) && gen_rdata.in_use && (gen_rdata.gen == gen_q);

  always_comb begin
    state_d      = state_q;
    fsc_d        = fsc_q;
    used_d       = used_q;
    req_d        = req_q;
    idx_d        = idx_q;
    gen_d        = gen_q;
    slot_d       = slot_q;
    res_load     = 1'b0;
    out_idx_d    = idx_q;
    out_gen_d    = '0;
    out_live_d   = 1'b0;
    out_status_d = ST_OK;
    gen_re       = 1'b0;
    gen_raddr    = s_axis_tdata[IDX_W-1:0];
    gen_we       = 1'b0;
    gen_waddr    = idx_q;
    gen_wdata    = '0;
    stk_re       = 1'b0;
    stk_raddr    = fsc_q[IDX_W-1:0] - IDX_W'(1);
    stk_we       = 1'b0;
    stk_waddr    = fsc_q[IDX_W-1:0];
    stk_wdata    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = s_axis_tuser[1:0];
          idx_d   = s_axis_tdata[IDX_W-1:0];
          gen_d   = s_axis_tdata[IDX_W +: GEN_W];
          gen_re  = 1'b1;
          stk_re  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q == REQ_ALLOC && fsc_q != '0) begin
          // pop recycled index, then fetch its generation
          fsc_d     = fsc_q - CNT_W'(1);
          slot_d    = stk_rdata;
          gen_re    = 1'b1;
          gen_raddr = stk_rdata;
          state_d   = S_POP;
        end else if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          case (req_q)
            REQ_ALLOC: begin
              if (used_q < CNT_W'(CAPACITY)) begin
                out_idx_d = used_q[IDX_W-1:0];
                gen_we    = 1'b1;
                gen_waddr = used_q[IDX_W-1:0];
                gen_wdata = '{in_use: 1'b1, gen: '0};
                used_d    = used_q + CNT_W'(1);
              end else begin
                out_idx_d    = '0;
                out_status_d = ST_FULL;
              end
            end
            REQ_FREE: begin
              if (hit && fsc_q < CNT_W'(CAPACITY)) begin
                gen_we     = 1'b1;
                gen_wdata  = '{in_use: 1'b0, gen: gen_rdata.gen + GEN_W'(1)};
                stk_we     = 1'b1;
                fsc_d      = fsc_q + CNT_W'(1);
                out_live_d = 1'b1;
              end else begin
                out_status_d = ST_INVALID;
              end
            end
            REQ_CHECK: begin
              if (hit) begin
                out_live_d = 1'b1;
              end else begin
                out_status_d = ST_INVALID;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          res_load  = 1'b1;
          out_idx_d = slot_q;
          out_gen_d = gen_rdata.gen;
          gen_we    = 1'b1;
          gen_waddr = slot_q;
          gen_wdata = '{in_use: 1'b1, gen: gen_rdata.gen};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fsc_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fsc_q   <= fsc_d;
      used_q  <= used_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    gen_q  <= gen_d;
    slot_q <= slot_d;
    if (res_load) begin
      out_idx_q    <= out_idx_d;
      out_gen_q    <= out_gen_d;
      out_live_q   <= out_live_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(32 - IDX_W - GEN_W){1'b0}}, out_gen_q, out_idx_q};
  assign m_axis_tuser  = {5'b0, out_status_q, out_live_q};

  `GHA_ASSERT(a_fsc_le_cap, fsc_q <= CNT_W'(CAPACITY), "free stack count above capacity")
  `GHA_ASSERT(a_fsc_le_used, fsc_q <= used_q, "more free indices than slots ever used")
  `GHA_ASSERT(a_used_mono, 1'b1 |=> used_q >= $past(used_q), "used slot count decreased")
  `GHA_ASSERT(a_pop_after_exec, state_q == S_POP |-> ($past(state_q) == S_EXEC || $past(state_q) == S_POP),
              "pop state entered without execute")
  `GHA_ASSERT_CLK(a_accept_exec, clk_i, rst_ni, accept |=> state_q == S_EXEC,
                  "accepted request did not start execution")

endmodule

@@ dv/generational_handle_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives allocate, free, check and unknown requests over the slave stream and
// scores every result against an in-bench model or a typed row's result:
// a directed table, a short run of free and reallocate rounds on one slot,
// then a random fill-and-churn run with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;
  import gha_pkg::*;

  localparam logic [1:0]  REQ_NONE    = 2'd3;  // unknown request code
  localparam int unsigned NUM_ROWS    = 22;
  localparam int unsigned RAND_ITEMS  = 1200;
  localparam int unsigned WRAP_SLOT   = 2;
  localparam int unsigned WRAP_ROUNDS = 16;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic             live;
    logic [1:0]       status;
  } alloc_result_t;

  typedef struct packed {
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic             typed;
    alloc_result_t    res;
  } req_row_t;

  // typed rows carry the result by hand, the rest are scored by the model
  localparam req_row_t REQ_ROWS [NUM_ROWS] = '{
    '{REQ_ALLOC, 10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b0, ST_OK}},
    '{REQ_ALLOC, 10'd0,    16'd0,     1'b1, '{10'd1,    16'd0, 1'b0, ST_OK}},
    '{REQ_CHECK, 10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b1, ST_OK}},
    '{REQ_CHECK, 10'd1,    16'd5,     1'b1, '{10'd1,    16'd0, 1'b0, ST_INVALID}},
    '{REQ_FREE,  10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b1, ST_OK}},
    '{REQ_FREE,  10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b0, ST_INVALID}},
    '{REQ_CHECK, 10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b0, ST_INVALID}},
    '{REQ_ALLOC, 10'd1023, 16'd65535, 1'b1, '{10'd0,    16'd1, 1'b0, ST_OK}},
    '{REQ_CHECK, 10'd0,    16'd1,     1'b1, '{10'd0,    16'd0, 1'b1, ST_OK}},
    '{REQ_CHECK, 10'd1023, 16'd0,     1'b1, '{10'd1023, 16'd0, 1'b0, ST_INVALID}},
    '{REQ_FREE,  10'd1023, 16'd65535, 1'b1, '{10'd1023, 16'd0, 1'b0, ST_INVALID}},
    '{REQ_NONE,  10'd1023, 16'd65535, 1'b1, '{10'd1023, 16'd0, 1'b0, ST_OK}},
    '{REQ_NONE,  10'd0,    16'd0,     1'b1, '{10'd0,    16'd0, 1'b0, ST_OK}},
    '{REQ_FREE,  10'd1,    16'd0,     1'b1, '{10'd1,    16'd0, 1'b1, ST_OK}},
    '{REQ_FREE,  10'd0,    16'd1,     1'b1, '{10'd0,    16'd0, 1'b1, ST_OK}},
    '{REQ_ALLOC, 10'd0,    16'd0,     1'b1, '{10'd0,    16'd2, 1'b0, ST_OK}},
    '{REQ_ALLOC, 10'd0,    16'd0,     1'b1, '{10'd1,    16'd1, 1'b0, ST_OK}},
    '{REQ_ALLOC, 10'd0,    16'd0,     1'b1, '{10'd2,    16'd0, 1'b0, ST_OK}},
    '{REQ_CHECK, 10'd1,    16'd0,     1'b1, '{10'd1,    16'd0, 1'b0, ST_INVALID}},
    '{REQ_CHECK, 10'd1,    16'd1,     1'b0, '0},
    '{REQ_CHECK, 10'd2,    16'd65535, 1'b0, '0},
    '{REQ_FREE,  10'd2,    16'd1,     1'b1, '{10'd2,    16'd0, 1'b0, ST_INVALID}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [9:0] handle_index, [25:10] handle_generation
  logic [7:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [9:0] out_index, [25:10] out_generation
  logic [7:0]  m_axis_tuser;   // [0] is_live, [2:1] status

  // allocator model state
  logic [GEN_W-1:0] slot_gen   [CAPACITY];
  bit               slot_live  [CAPACITY];
  logic [IDX_W-1:0] free_stack [CAPACITY];
  int unsigned      free_count;
  int unsigned      used_count;

  alloc_result_t pending_results [$];
  alloc_result_t got_res;
  alloc_result_t want_res;
  int unsigned   err_count;
  int unsigned   cycle_count;
  bit            idle_en;

  generational_handle_allocator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit handle_ok(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen);
    return (idx < used_count) && slot_live[idx] && (slot_gen[idx] == gen);
  endfunction

  // advance the model by one request and return its result
  function automatic alloc_result_t alloc_response(input logic [1:0] req,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [GEN_W-1:0] gen);
    alloc_result_t    res;
    logic [IDX_W-1:0] slot;
    res = '{idx, '0, 1'b0, ST_OK};
    case (req)
      REQ_ALLOC: begin
        if (free_count > 0 || used_count < CAPACITY) begin
          if (free_count > 0) begin
            free_count--;
            slot = free_stack[free_count];
          end else begin
            slot = used_count[IDX_W-1:0];
            used_count++;
            slot_gen[slot] = '0;
          end
          slot_live[slot] = 1'b1;
          res.idx = slot;
          res.gen = slot_gen[slot];
        end else begin
          res.idx    = '0;
          res.status = ST_FULL;
        end
      end
      REQ_FREE: begin
        if (handle_ok(idx, gen)) begin
          slot_gen[idx]          = slot_gen[idx] + 1'b1;
          slot_live[idx]         = 1'b0;
          free_stack[free_count] = idx;
          free_count++;
          res.live = 1'b1;
        end else begin
          res.status = ST_INVALID;
        end
      end
      REQ_CHECK: begin
        if (handle_ok(idx, gen)) res.live = 1'b1;
        else res.status = ST_INVALID;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit pick_live_slot(output logic [IDX_W-1:0] idx);
    int unsigned start;
    int unsigned j;
    idx = '0;
    if (used_count == 0) return 1'b0;
    start = $urandom_range(used_count - 1);
    for (int unsigned k = 0; k < used_count; k++) begin
      j = (start + k) % used_count;
      if (slot_live[j]) begin
        idx = j[IDX_W-1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // drive one request, wait for its transfer, then queue the expected result
  task automatic send_req(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                          input logic [GEN_W-1:0] gen, input bit typed,
                          input alloc_result_t typed_res, output alloc_result_t res);
    int unsigned gap;
    gap = (idle_en && $urandom_range(99) < 19) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, gen, idx};
    s_axis_tuser  <= {6'd0, req};
    do @(posedge clk_i); while (!s_axis_tready);
    res = alloc_response(req, idx, gen);
    if (typed) res = typed_res;
    pending_results.insert(pending_results.size(), res);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !(idle_en && $urandom_range(99) < 19);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("generational_handle_allocator_unit_tb: done, errors");
      $finish;
    end
  end

  // score each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = '{m_axis_tdata[9:0], m_axis_tdata[25:10], m_axis_tuser[0],
                  m_axis_tuser[2:1]};
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: idx %0d gen %0d live %0d status %0d",
                   got_res.idx, got_res.gen, got_res.live, got_res.status);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.idx !== want_res.idx || got_res.gen !== want_res.gen ||
            got_res.live !== want_res.live || got_res.status !== want_res.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"mismatch: exp idx %0d gen %0d live %0d status %0d,",
                      " got idx %0d gen %0d live %0d status %0d"},
                     want_res.idx, want_res.gen, want_res.live, want_res.status,
                     got_res.idx, got_res.gen, got_res.live, got_res.status);
        end
      end
    end
  end

  initial begin
    alloc_result_t    res;
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    int unsigned      pick;
    int unsigned      full_hits;
    bit               found;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    idle_en       = 1'b1;
    free_count    = 0;
    used_count    = 0;
    full_hits     = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_gen[i]   = '0;
      slot_live[i]  = 1'b0;
      free_stack[i] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++)
      send_req(REQ_ROWS[r].req, REQ_ROWS[r].idx, REQ_ROWS[r].gen, REQ_ROWS[r].typed,
               REQ_ROWS[r].res, res);

    // free and reallocate one slot, advancing its generation each round
    for (int w = 0; w < WRAP_ROUNDS; w++) begin
      send_req(REQ_FREE, WRAP_SLOT[IDX_W-1:0], slot_gen[WRAP_SLOT], 1'b0, '0, res);
      send_req(REQ_ALLOC, '0, '0, 1'b0, '0, res);
    end

    // fill the allocator until it reports full, then churn near capacity
    for (int n = 0; n < RAND_ITEMS || full_hits < 4; n++) begin
      idle_en = !(n >= 400 && n < 800);
      pick    = $urandom_range(99);
      if (full_hits == 0)
        pick = (pick < 88) ? 0 : (pick < 92) ? 30 : (pick < 96) ? 60 : (pick < 98) ? 80 : 95;
      req = REQ_ALLOC;
      idx = IDX_W'($urandom_range(CAPACITY - 1));
      gen = GEN_W'($urandom_range(16'hFFFF));
      if (pick >= 30 && pick < 78) begin
        found = pick_live_slot(idx);
        req   = !found ? REQ_ALLOC : (pick < 60) ? REQ_FREE : REQ_CHECK;
        gen   = slot_gen[idx];
      end else if (pick >= 78 && pick < 90) begin
        req = $urandom_range(1) ? REQ_FREE : REQ_CHECK;
        case ($urandom_range(2))
          0: if (pick_live_slot(idx))
               gen = slot_gen[idx] + GEN_W'($urandom_range(1, 16'hFFFF));
          1: if (used_count > 0) idx = IDX_W'($urandom_range(used_count - 1));
          default: if (used_count < CAPACITY)
                     idx = IDX_W'($urandom_range(CAPACITY - 1, used_count));
        endcase
      end else if (pick >= 90) begin
        req = 2'($urandom_range(3));
      end
      send_req(req, idx, gen, 1'b0, '0, res);
      if (res.status == ST_FULL) full_hits++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("generational_handle_allocator_unit_tb: done, clean");
    end else begin
      $display("generational_handle_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
